// ----- hw/rtl/task_lifecycle_supervisor_core_assert.svh -----
// Assertion macros shared by the supervisor checker.
`ifndef TASK_LIFECYCLE_SUPERVISOR_CORE_ASSERT_SVH
`define TASK_LIFECYCLE_SUPERVISOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tls_pkg.sv -----
// Shared types and codes for the task lifecycle supervisor.
`default_nettype none

package tls_pkg;

    localparam int REG_W       = 22;
    localparam int EVENT_KEY_W = 32;
    localparam int REASON_W    = 4;
    localparam int OUT_TDATA_W = 40;
    localparam int DUR_W       = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [REG_W-1:0] SETTLE_MARGIN_MS = 22'd1000;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_ABORT    = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;

    // Action name codes.
    localparam logic [1:0] ACT_ABSENT = 2'd0;
    localparam logic [1:0] ACT_THIS   = 2'd1;

    // Valid mask codes.
    localparam logic [1:0] MASK_ROAD     = 2'd1;
    localparam logic [1:0] MASK_SIDEWALK = 2'd2;

    // Event codes carried on the output tuser.
    localparam logic [1:0] EV_STARTED   = 2'd0;
    localparam logic [1:0] EV_COMPLETED = 2'd1;
    localparam logic [1:0] EV_REJECTED  = 2'd2;
    localparam logic [1:0] EV_ABORTED   = 2'd3;

    // Reason codes.
    localparam logic [REASON_W-1:0] RSN_NONE          = 4'd0;
    localparam logic [REASON_W-1:0] RSN_SERVER_ABORT  = 4'd1;
    localparam logic [REASON_W-1:0] RSN_BUSY          = 4'd2;
    localparam logic [REASON_W-1:0] RSN_BAD_PAYLOAD   = 4'd3;
    localparam logic [REASON_W-1:0] RSN_BAD_MASK      = 4'd4;
    localparam logic [REASON_W-1:0] RSN_BAD_DURATION  = 4'd5;
    localparam logic [REASON_W-1:0] RSN_NOT_READY     = 4'd6;
    localparam logic [REASON_W-1:0] RSN_UNSAFE        = 4'd7;
    localparam logic [REASON_W-1:0] RSN_TRACKING_LOST = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_STARTUP_HOLD   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNSAFE_TIMEOUT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_DUR    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DUR        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_MASK   = 3'd4;

    typedef struct packed {
        logic [REG_W-1:0] startup_hold;
        logic [REG_W-1:0] unsafe_timeout;
        logic [REG_W-1:0] default_duration;
        logic [REG_W-1:0] max_duration;
    } cfg_t;

    typedef struct packed {
        logic       key_valid;
        logic [1:0] action_code;
        logic       payload_bad;
        logic       mask_given;
        logic [1:0] mask_value;
        logic       duration_given;
        logic       tracking_ok;
    } req_flags_t;

    typedef struct packed {
        logic                valid;
        logic [1:0]          task_event;
        logic [REASON_W-1:0] reason_code;
    } result_t;

    // Control bits that travel with a key probe along the history row.
    typedef struct packed {
        logic valid;
        logic hit;
    } probe_t;

endpackage

`default_nettype wire

// ----- hw/rtl/task_lifecycle_supervisor_core.sv -----
// Task lifecycle supervisor: a register request, an abort request or a time tick comes in
// on the slave stream, and at most one task event goes out on the master stream. Register
// requests are checked against the HISTORY_DEPTH most recent keys, kept in a row of cells
// that a probe walks through one cell per clock; such a request waits in the search state
// until the probe leaves the last cell, while aborts, ticks and requests that are ignored
// up front skip the row. One item is handled at a time. A finished event waits in an
// output register, and the next item is taken while it waits; an item that produces an
// event stalls only when that register is still full. Configuration writes belong to idle
// periods between items.
`default_nettype none

module task_lifecycle_supervisor_core #(
    parameter int HISTORY_DEPTH = 256,
    parameter int KEY_WIDTH     = 32,
    parameter int TIME_WIDTH    = 32,
    localparam int IN_BITS      = TIME_WIDTH + KEY_WIDTH + 41,
    localparam int IN_W         = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // now_ms, task_key, key_valid, action_code, payload_bad, mask_given, mask_value,
    // duration_given, duration_ms, tracking_ok, zero fill
    input  wire logic [IN_W-1:0]                s_tdata,
    // req_type
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // event_key, reason_code, zero fill
    output logic [tls_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // task_event
    output logic [1:0]                          m_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [tls_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [tls_pkg::REG_W-1:0]      cfg_wdata
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    localparam int O_KEY = TIME_WIDTH;
    localparam int O_KV  = O_KEY + KEY_WIDTH;
    localparam int O_ACT = O_KV + 1;
    localparam int O_PB  = O_ACT + 2;
    localparam int O_MG  = O_PB + 1;
    localparam int O_MV  = O_MG + 1;
    localparam int O_DG  = O_MV + 2;
    localparam int O_DUR = O_DG + 1;
    localparam int O_TRK = O_DUR + tls_pkg::DUR_W;
    localparam int PAD_W = tls_pkg::OUT_TDATA_W - tls_pkg::EVENT_KEY_W - tls_pkg::REASON_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic                             launch_reg;
    logic                             hit_reg;
    logic [CNT_W-1:0]                 count_reg;

    logic [1:0]                       type_reg;
    tls_pkg::req_flags_t              flags_reg;
    tls_pkg::req_flags_t              flags_in;
    logic [TIME_WIDTH-1:0]            now_reg;
    logic [KEY_WIDTH-1:0]             key_reg;
    logic [tls_pkg::DUR_W-1:0]        dur_reg;

    tls_pkg::cfg_t                    cfg_reg;

    logic                             m_tvalid_reg;
    logic [1:0]                       m_event_reg;
    logic [tls_pkg::EVENT_KEY_W-1:0]  m_key_reg;
    logic [tls_pkg::REASON_W-1:0]     m_reason_reg;

    tls_pkg::result_t                 result;
    logic [tls_pkg::EVENT_KEY_W-1:0]  result_key;
    logic                             record;
    logic                             commit;
    logic                             in_accept;
    logic                             needs_search;

    logic [KEY_WIDTH-1:0]             hist_key   [0:HISTORY_DEPTH];
    tls_pkg::probe_t                  probe      [0:HISTORY_DEPTH];
    logic [KEY_WIDTH-1:0]             probe_key  [0:HISTORY_DEPTH];
    logic [CNT_W-1:0]                 probe_live [0:HISTORY_DEPTH];

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    assign flags_in.key_valid      = s_tdata[O_KV];
    assign flags_in.action_code    = s_tdata[O_ACT +: 2];
    assign flags_in.payload_bad    = s_tdata[O_PB];
    assign flags_in.mask_given     = s_tdata[O_MG];
    assign flags_in.mask_value     = s_tdata[O_MV +: 2];
    assign flags_in.duration_given = s_tdata[O_DG];
    assign flags_in.tracking_ok    = s_tdata[O_TRK];

    // Only a matching register request with a valid key consults the history.
    assign needs_search = (s_tuser == tls_pkg::REQ_REGISTER) && flags_in.key_valid
                          && (flags_in.action_code == tls_pkg::ACT_THIS);

    assign commit = (state_reg == ST_DECIDE) && (!result.valid || !m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = needs_search ? ST_SEARCH : ST_DECIDE;
                end
            end
            ST_SEARCH:
            begin
                if (probe[HISTORY_DEPTH].valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= in_accept && needs_search;
            if (commit && record && (count_reg != CNT_W'(HISTORY_DEPTH)))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            type_reg  <= s_tuser;
            flags_reg <= flags_in;
            now_reg   <= s_tdata[TIME_WIDTH-1:0];
            key_reg   <= s_tdata[O_KEY +: KEY_WIDTH];
            dur_reg   <= s_tdata[O_DUR +: tls_pkg::DUR_W];
            hit_reg   <= 1'b0;
        end
        else if ((state_reg == ST_SEARCH) && probe[HISTORY_DEPTH].valid)
        begin
            hit_reg <= probe[HISTORY_DEPTH].hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_hold     <= 22'd2000;
            cfg_reg.unsafe_timeout   <= 22'd1000;
            cfg_reg.default_duration <= 22'd30000;
            cfg_reg.max_duration     <= 22'd600000;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                tls_pkg::CFG_STARTUP_HOLD:   cfg_reg.startup_hold     <= cfg_wdata;
                tls_pkg::CFG_UNSAFE_TIMEOUT: cfg_reg.unsafe_timeout   <= cfg_wdata;
                tls_pkg::CFG_DEFAULT_DUR:    cfg_reg.default_duration <= cfg_wdata;
                tls_pkg::CFG_MAX_DUR:        cfg_reg.max_duration     <= cfg_wdata;
                // The coverage mask never shows on an event, so it is not stored.
                tls_pkg::CFG_DEFAULT_MASK:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Probe entry: the newest key sits in cell 0, and the live count covers filled cells.
    assign hist_key[0]   = key_reg;
    assign probe[0]      = '{launch_reg, 1'b0};
    assign probe_key[0]  = key_reg;
    assign probe_live[0] = count_reg;

    for (genvar i = 0; i < HISTORY_DEPTH; i++)
    begin : g_cell
        tls_hist_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .shift_en       (commit && record),
            .hist_key_in    (hist_key[i]),
            .hist_key_out   (hist_key[i+1]),
            .probe_in       (probe[i]),
            .probe_key_in   (probe_key[i]),
            .probe_live_in  (probe_live[i]),
            .probe_out      (probe[i+1]),
            .probe_key_out  (probe_key[i+1]),
            .probe_live_out (probe_live[i+1])
        );
    end

    tls_supervisor #(
        .KEY_WIDTH  (KEY_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_supervisor (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (commit),
        .cfg         (cfg_reg),
        .req_type    (type_reg),
        .flags       (flags_reg),
        .now_ms      (now_reg),
        .task_key    (key_reg),
        .duration_ms (dur_reg),
        .hit         (hit_reg),
        .result      (result),
        .result_key  (result_key),
        .record      (record)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit && result.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && result.valid)
        begin
            m_event_reg  <= result.task_event;
            m_key_reg    <= result_key;
            m_reason_reg <= result.reason_code;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_reason_reg, m_key_reg};
    assign m_tuser  = m_event_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tls_hist_cell.sv -----
// One cell of the key history row: a stored key and a passing probe stage.
`default_nettype none

module tls_hist_cell #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 9
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift_en,
    input  wire logic [KEY_WIDTH-1:0] hist_key_in,
    output logic      [KEY_WIDTH-1:0] hist_key_out,
    input  wire tls_pkg::probe_t      probe_in,
    input  wire logic [KEY_WIDTH-1:0] probe_key_in,
    input  wire logic [CNT_W-1:0]     probe_live_in,
    output tls_pkg::probe_t           probe_out,
    output logic      [KEY_WIDTH-1:0] probe_key_out,
    output logic      [CNT_W-1:0]     probe_live_out
);

    logic [KEY_WIDTH-1:0] stored_key_reg;
    logic                 probe_valid_reg;
    logic                 probe_hit_reg;
    logic                 probe_hit_next;
    logic [KEY_WIDTH-1:0] probe_key_reg;
    logic [CNT_W-1:0]     probe_live_reg;
    logic [CNT_W-1:0]     probe_live_next;
    logic                 live_nz;

    // The live count says how many cells from here on hold recorded keys.
    assign live_nz         = (probe_live_in != '0);
    assign probe_hit_next  = probe_in.hit | (live_nz & (probe_key_in == stored_key_reg));
    assign probe_live_next = probe_live_in - CNT_W'(live_nz);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
        end
        else
        begin
            probe_valid_reg <= probe_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            stored_key_reg <= hist_key_in;
        end
        probe_hit_reg  <= probe_hit_next;
        probe_key_reg  <= probe_key_in;
        probe_live_reg <= probe_live_next;
    end

    assign hist_key_out    = stored_key_reg;
    assign probe_out.valid = probe_valid_reg;
    assign probe_out.hit   = probe_hit_reg;
    assign probe_key_out   = probe_key_reg;
    assign probe_live_out  = probe_live_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tls_supervisor.sv -----
// Task state and the decision that one request or tick makes on it.
`default_nettype none

module tls_supervisor #(
    parameter int KEY_WIDTH  = 32,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  commit,
    input  wire tls_pkg::cfg_t         cfg,
    input  wire logic [1:0]            req_type,
    input  wire tls_pkg::req_flags_t   flags,
    input  wire logic [TIME_WIDTH-1:0] now_ms,
    input  wire logic [KEY_WIDTH-1:0]  task_key,
    input  wire logic [tls_pkg::DUR_W-1:0] duration_ms,
    input  wire logic                  hit,
    output tls_pkg::result_t           result,
    output logic [tls_pkg::EVENT_KEY_W-1:0] result_key,
    output logic                       record
);

    localparam int CW = (TIME_WIDTH > tls_pkg::DUR_W) ? TIME_WIDTH : tls_pkg::DUR_W;
    localparam int REG_W_P1 = tls_pkg::REG_W + 1;

    logic                      running_reg,      running_next;
    logic                      seen_reg,         seen_next;
    logic                      pending_reg,      pending_next;
    logic [KEY_WIDTH-1:0]      running_key_reg,  running_key_next;
    logic [TIME_WIDTH-1:0]     start_time_reg,   start_time_next;
    logic [tls_pkg::DUR_W-1:0] run_length_reg,   run_length_next;
    logic [TIME_WIDTH-1:0]     unsafe_start_reg, unsafe_start_next;

    logic [TIME_WIDTH-1:0]     elapsed;
    logic [TIME_WIDTH-1:0]     unsafe_elapsed;
    logic                      in_hold;
    logic                      run_over;
    logic                      unsafe_over;
    logic                      req_match;
    logic                      mask_bad;
    logic                      dur_bad;
    logic                      abort_match;
    logic [REG_W_P1-1:0]       hold_plus_margin;
    logic                      use_running_key;

    assign elapsed        = now_ms - start_time_reg;
    assign unsafe_elapsed = now_ms - unsafe_start_reg;
    assign in_hold        = CW'(elapsed) < CW'(cfg.startup_hold);
    assign run_over       = CW'(elapsed) >= CW'(run_length_reg);
    assign unsafe_over    = CW'(unsafe_elapsed) >= CW'(cfg.unsafe_timeout);

    assign hold_plus_margin = REG_W_P1'(cfg.startup_hold) + REG_W_P1'(tls_pkg::SETTLE_MARGIN_MS);

    assign req_match = flags.key_valid && (flags.action_code == tls_pkg::ACT_THIS);
    assign mask_bad  = flags.mask_given && (flags.mask_value != tls_pkg::MASK_ROAD)
                       && (flags.mask_value != tls_pkg::MASK_SIDEWALK);
    assign dur_bad   = flags.duration_given
                       && ((duration_ms < tls_pkg::DUR_W'(hold_plus_margin))
                           || (duration_ms > tls_pkg::DUR_W'(cfg.max_duration)));
    assign abort_match = running_reg && flags.key_valid && (task_key == running_key_reg)
                         && ((flags.action_code == tls_pkg::ACT_ABSENT)
                             || (flags.action_code == tls_pkg::ACT_THIS));

    always_comb
    begin
        running_next      = running_reg;
        seen_next         = seen_reg;
        pending_next      = pending_reg;
        running_key_next  = running_key_reg;
        start_time_next   = start_time_reg;
        run_length_next   = run_length_reg;
        unsafe_start_next = unsafe_start_reg;
        result            = '0;
        record            = 1'b0;
        use_running_key   = 1'b0;

        case (req_type)
            tls_pkg::REQ_ABORT:
            begin
                if (abort_match)
                begin
                    result          = '{1'b1, tls_pkg::EV_ABORTED, tls_pkg::RSN_SERVER_ABORT};
                    use_running_key = 1'b1;
                    running_next    = 1'b0;
                    seen_next       = 1'b0;
                    pending_next    = 1'b0;
                end
            end
            tls_pkg::REQ_REGISTER:
            begin
                if (req_match && !hit)
                begin
                    record = 1'b1;
                    if (running_reg)
                    begin
                        result = '{1'b1, tls_pkg::EV_REJECTED, tls_pkg::RSN_BUSY};
                    end
                    else if (flags.payload_bad)
                    begin
                        result = '{1'b1, tls_pkg::EV_REJECTED, tls_pkg::RSN_BAD_PAYLOAD};
                    end
                    else if (mask_bad)
                    begin
                        result = '{1'b1, tls_pkg::EV_REJECTED, tls_pkg::RSN_BAD_MASK};
                    end
                    else if (dur_bad)
                    begin
                        result = '{1'b1, tls_pkg::EV_REJECTED, tls_pkg::RSN_BAD_DURATION};
                    end
                    else if (!flags.tracking_ok)
                    begin
                        result = '{1'b1, tls_pkg::EV_REJECTED, tls_pkg::RSN_NOT_READY};
                    end
                    else
                    begin
                        result           = '{1'b1, tls_pkg::EV_STARTED, tls_pkg::RSN_NONE};
                        running_next     = 1'b1;
                        running_key_next = task_key;
                        start_time_next  = now_ms;
                        run_length_next  = flags.duration_given ? duration_ms
                                           : tls_pkg::DUR_W'(cfg.default_duration);
                        seen_next        = 1'b0;
                        pending_next     = 1'b0;
                    end
                end
            end
            tls_pkg::REQ_TICK:
            begin
                if (running_reg && !in_hold)
                begin
                    use_running_key = 1'b1;
                    if (flags.tracking_ok)
                    begin
                        seen_next    = 1'b1;
                        pending_next = 1'b0;
                    end
                    else if (!pending_reg)
                    begin
                        pending_next      = 1'b1;
                        unsafe_start_next = now_ms;
                    end

                    // The unsafe timeout wins over completion on the same tick.
                    if (!flags.tracking_ok && pending_reg && unsafe_over)
                    begin
                        result = '{1'b1, tls_pkg::EV_ABORTED, tls_pkg::RSN_UNSAFE};
                    end
                    else if (run_over)
                    begin
                        if (seen_reg && flags.tracking_ok)
                        begin
                            result = '{1'b1, tls_pkg::EV_COMPLETED, tls_pkg::RSN_NONE};
                        end
                        else
                        begin
                            result = '{1'b1, tls_pkg::EV_ABORTED, tls_pkg::RSN_TRACKING_LOST};
                        end
                    end

                    if (result.valid)
                    begin
                        running_next = 1'b0;
                        seen_next    = 1'b0;
                        pending_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_key = use_running_key ? tls_pkg::EVENT_KEY_W'(running_key_reg)
                                        : tls_pkg::EVENT_KEY_W'(task_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            seen_reg    <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (commit)
        begin
            running_reg <= running_next;
            seen_reg    <= seen_next;
            pending_reg <= pending_next;
        end
    end

    // These only matter while a task runs or a non-tracking spell is pending.
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            running_key_reg  <= running_key_next;
            start_time_reg   <= start_time_next;
            run_length_reg   <= run_length_next;
            unsafe_start_reg <= unsafe_start_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tls_checker.sv -----
// Port-level checks for the task lifecycle supervisor and their binding.
`default_nettype none

`include "task_lifecycle_supervisor_core_assert.svh"

module tls_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [tls_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic [1:0]                         m_tuser
);

    logic [tls_pkg::REASON_W-1:0] reason;

    assign reason = m_tdata[tls_pkg::EVENT_KEY_W +: tls_pkg::REASON_W];

    `TLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled event changed")

    `TLS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while an item is in work")

    `TLS_ASSERT_NOW(a_no_reason_ok, m_tvalid && ((m_tuser == tls_pkg::EV_STARTED) || (m_tuser == tls_pkg::EV_COMPLETED)), reason == tls_pkg::RSN_NONE, "start or completion carries a reason")

    `TLS_ASSERT_NOW(a_reject_reason, m_tvalid && (m_tuser == tls_pkg::EV_REJECTED), (reason >= tls_pkg::RSN_BUSY) && (reason <= tls_pkg::RSN_NOT_READY), "rejection with a wrong reason")

    `TLS_ASSERT_NOW(a_abort_reason, m_tvalid && (m_tuser == tls_pkg::EV_ABORTED), (reason == tls_pkg::RSN_SERVER_ABORT) || (reason == tls_pkg::RSN_UNSAFE) || (reason == tls_pkg::RSN_TRACKING_LOST), "abort with a wrong reason")

endmodule

bind task_lifecycle_supervisor_core tls_checker u_tls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking stream testbench for the task lifecycle supervisor core.
module testbench;

    import tls_pkg::*;

    localparam int IN_W          = 112;
    localparam int HISTORY       = 256;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int PHASE_ITEMS   = 215;
    localparam int HOLD_A_START  = 25000;
    localparam int HOLD_B_START  = 80000;
    localparam int HOLD_LENGTH   = 3000;

    localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
    localparam logic [1:0] ACT_OTHER       = 2'd2;
    localparam logic [1:0] MASK_INVALID_LO = 2'd0;
    localparam logic [1:0] MASK_INVALID_HI = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
        logic [31:0] key;
        logic        key_valid;
        logic [1:0]  action;
        logic        payload_bad;
        logic        mask_given;
        logic [1:0]  mask_value;
        logic        duration_given;
        logic [31:0] duration;
        logic        tracking;
    } request_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [31:0]         key;
        logic [REASON_W-1:0] reason;
    } task_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [REG_W-1:0]      cfg_wdata = '0;

    task_lifecycle_supervisor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Supervisor register copy.
    logic [REG_W-1:0] hold_ms     = 22'd2000;
    logic [REG_W-1:0] unsafe_ms   = 22'd1000;
    logic [REG_W-1:0] dflt_dur_ms = 22'd30000;
    logic [REG_W-1:0] max_dur_ms  = 22'd600000;
    logic [1:0]       dflt_mask   = MASK_ROAD;

    // Supervisor state copy.
    logic [31:0] hist_keys [HISTORY];
    logic [7:0]  hist_head    = '0;
    logic [8:0]  hist_count   = '0;
    logic        busy         = 1'b0;
    logic [31:0] active_key   = '0;
    logic [31:0] active_start = '0;
    logic [31:0] active_len   = '0;
    logic [1:0]  active_mask  = MASK_ROAD;
    logic        tracked      = 1'b0;
    logic        unsafe_armed = 1'b0;
    logic [31:0] unsafe_since = '0;

    request_t    pending_requests[$];
    task_event_t expected_events[$];
    logic [31:0] known_keys[$];

    request_t    in_flight;
    task_event_t outcome;
    task_event_t want;
    int          tx_wait = 0;
    bit          tx_calm = 1'b0;
    int          rx_wait = 0;
    bit          rx_calm = 1'b0;
    int          rx_cycle = 0;
    int          cycle_count = 0;
    int          fail_count = 0;
    int          stim_items = 0;
    logic [31:0] stim_now = '0;
    logic [31:0] live_key = '0;

    function automatic task_event_t retire_task(logic [1:0] kind, logic [REASON_W-1:0] reason);
        task_event_t ev;
        ev.kind = kind;
        ev.key = active_key;
        ev.reason = reason;
        busy = 1'b0;
        tracked = 1'b0;
        unsafe_armed = 1'b0;
        return ev;
    endfunction

    // Advances the supervisor copy by one request; returns 1 when it emits a task event.
    function automatic bit supervise(input request_t r, output task_event_t ev);
        logic [31:0] elapsed;
        logic [32:0] floor_ms;
        logic [1:0]  mask;
        logic [31:0] len;
        bit          was_tracked;
        ev.kind = EV_REJECTED;
        ev.key = r.key;
        ev.reason = RSN_NONE;
        case (r.kind)
            REQ_ABORT:
            begin
                if (busy && r.key_valid && r.key == active_key
                        && (r.action == ACT_ABSENT || r.action == ACT_THIS))
                begin
                    ev = retire_task(EV_ABORTED, RSN_SERVER_ABORT);
                    return 1'b1;
                end
                return 1'b0;
            end
            REQ_REGISTER:
            begin
                if (r.action != ACT_THIS || !r.key_valid)
                    return 1'b0;
                for (int i = 0; i < hist_count; i++)
                    if (hist_keys[i] == r.key)
                        return 1'b0;
                hist_keys[hist_head] = r.key;
                hist_head = hist_head + 8'd1;
                if (hist_count < HISTORY)
                    hist_count = hist_count + 9'd1;
                if (busy)
                begin
                    ev.reason = RSN_BUSY;
                    return 1'b1;
                end
                if (r.payload_bad)
                begin
                    ev.reason = RSN_BAD_PAYLOAD;
                    return 1'b1;
                end
                mask = dflt_mask;
                if (r.mask_given)
                begin
                    if (r.mask_value != MASK_ROAD && r.mask_value != MASK_SIDEWALK)
                    begin
                        ev.reason = RSN_BAD_MASK;
                        return 1'b1;
                    end
                    mask = r.mask_value;
                end
                len = {10'd0, dflt_dur_ms};
                if (r.duration_given)
                begin
                    floor_ms = {11'd0, hold_ms} + {11'd0, SETTLE_MARGIN_MS};
                    if ({1'b0, r.duration} < floor_ms || r.duration > {10'd0, max_dur_ms})
                    begin
                        ev.reason = RSN_BAD_DURATION;
                        return 1'b1;
                    end
                    len = r.duration;
                end
                if (!r.tracking)
                begin
                    ev.reason = RSN_NOT_READY;
                    return 1'b1;
                end
                busy = 1'b1;
                active_key = r.key;
                active_start = r.now;
                active_len = len;
                active_mask = mask;
                tracked = 1'b0;
                unsafe_armed = 1'b0;
                ev.kind = EV_STARTED;
                return 1'b1;
            end
            REQ_TICK:
            begin
                if (!busy)
                    return 1'b0;
                elapsed = r.now - active_start;
                if (elapsed < {10'd0, hold_ms})
                    return 1'b0;
                was_tracked = tracked;
                if (r.tracking)
                begin
                    tracked = 1'b1;
                    unsafe_armed = 1'b0;
                end
                else if (!unsafe_armed)
                begin
                    unsafe_armed = 1'b1;
                    unsafe_since = r.now;
                end
                else if (32'(r.now - unsafe_since) >= {10'd0, unsafe_ms})
                begin
                    ev = retire_task(EV_ABORTED, RSN_UNSAFE);
                    return 1'b1;
                end
                if (elapsed >= active_len)
                begin
                    if (was_tracked && r.tracking)
                        ev = retire_task(EV_COMPLETED, RSN_NONE);
                    else
                        ev = retire_task(EV_ABORTED, RSN_TRACKING_LOST);
                    return 1'b1;
                end
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Driver: offers queued requests and updates the prediction on every accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (supervise(in_flight, outcome))
                    expected_events.insert(expected_events.size(), outcome);
                if ($urandom_range(0, 39) == 0)
                    tx_calm = !tx_calm;
                tx_wait = tx_calm ? 0 : $urandom_range(0, 14);
            end
            if (s_tvalid && !s_tready)
            begin
                // Hold the offered transaction until it is taken.
            end
            else if (tx_wait > 0)
            begin
                tx_wait = tx_wait - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                in_flight = pending_requests[0];
                pending_requests.delete(0);
                s_tdata <= {7'd0, in_flight.tracking, in_flight.duration,
                            in_flight.duration_given, in_flight.mask_value, in_flight.mask_given,
                            in_flight.payload_bad, in_flight.action, in_flight.key_valid,
                            in_flight.key, in_flight.now};
                s_tuser  <= in_flight.kind;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: checks each task event and paces m_tready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle = rx_cycle + 1;
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected task event: task_event %0d event_key %h reason_code %0d",
                           m_tuser, m_tdata[EVENT_KEY_W-1:0], m_tdata[EVENT_KEY_W +: REASON_W]);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_events[0];
                    expected_events.delete(0);
                    if (m_tuser !== want.kind)
                    begin
                        $error("task_event: expected %0d, actual %0d", want.kind, m_tuser);
                        fail_count = fail_count + 1;
                    end
                    if (m_tdata[EVENT_KEY_W-1:0] !== want.key)
                    begin
                        $error("event_key: expected %h, actual %h", want.key,
                               m_tdata[EVENT_KEY_W-1:0]);
                        fail_count = fail_count + 1;
                    end
                    if (m_tdata[EVENT_KEY_W +: REASON_W] !== want.reason)
                    begin
                        $error("reason_code: expected %0d, actual %0d", want.reason,
                               m_tdata[EVENT_KEY_W +: REASON_W]);
                        fail_count = fail_count + 1;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
            end
            // Two long hold-offs let the output register fill and back up the input.
            if ((rx_cycle >= HOLD_A_START && rx_cycle < HOLD_A_START + HOLD_LENGTH)
                    || (rx_cycle >= HOLD_B_START && rx_cycle < HOLD_B_START + HOLD_LENGTH))
                m_tready <= 1'b0;
            else if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic request_t make_request(logic [1:0] kind, logic [31:0] now,
                                              logic [31:0] key);
        request_t r;
        r = '0;
        r.kind = kind;
        r.now = now;
        r.key = key;
        r.key_valid = 1'b1;
        r.action = ACT_THIS;
        r.tracking = 1'b1;
        return r;
    endfunction

    task automatic push_request(request_t r);
        pending_requests.insert(pending_requests.size(), r);
        if (r.kind == REQ_REGISTER && r.key_valid && r.action == ACT_THIS)
            known_keys.insert(known_keys.size(), r.key);
        if (known_keys.size() > 600)
            known_keys.delete(0);
        if (!(r.kind == REQ_UNKNOWN
                || (r.kind == REQ_REGISTER && (!r.key_valid || r.action != ACT_THIS))))
            stim_items = stim_items + 1;
    endtask

    // Waits until the block has drained every transaction and gone quiet.
    task automatic settle;
        while (pending_requests.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_registers(logic [REG_W-1:0] hold, logic [REG_W-1:0] unsafe_t,
                                     logic [REG_W-1:0] dflt_dur, logic [REG_W-1:0] max_dur,
                                     logic [REG_W-1:0] mask);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_STARTUP_HOLD;
        cfg_wdata <= hold;
        @(posedge clk);
        cfg_addr  <= CFG_UNSAFE_TIMEOUT;
        cfg_wdata <= unsafe_t;
        @(posedge clk);
        cfg_addr  <= CFG_DEFAULT_DUR;
        cfg_wdata <= dflt_dur;
        @(posedge clk);
        cfg_addr  <= CFG_MAX_DUR;
        cfg_wdata <= max_dur;
        @(posedge clk);
        cfg_addr  <= CFG_DEFAULT_MASK;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        hold_ms = hold;
        unsafe_ms = unsafe_t;
        dflt_dur_ms = dflt_dur;
        max_dur_ms = max_dur;
        dflt_mask = mask[1:0];
    endtask

    // A fresh register request followed by a run of ticks, with the odd abort or
    // competing request along the way.
    task automatic task_episode;
        request_t    r;
        logic [32:0] floor_ms;
        logic [33:0] reach;
        logic [31:0] span;
        logic [31:0] len;
        int          loss;
        r = make_request(REQ_REGISTER, stim_now, $urandom());
        floor_ms = {11'd0, hold_ms} + {11'd0, SETTLE_MARGIN_MS};
        if ($urandom_range(0, 1))
        begin
            r.mask_given = 1'b1;
            r.mask_value = $urandom_range(0, 1) ? MASK_ROAD : MASK_SIDEWALK;
        end
        if ($urandom_range(0, 1) && floor_ms <= {11'd0, max_dur_ms})
        begin
            r.duration_given = 1'b1;
            case ($urandom_range(0, 3))
                0: r.duration = floor_ms[31:0];
                1: r.duration = {10'd0, max_dur_ms};
                default: r.duration = $urandom_range(floor_ms[31:0], {10'd0, max_dur_ms});
            endcase
        end
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 5))
                0: r.payload_bad = 1'b1;
                1:
                begin
                    r.mask_given = 1'b1;
                    r.mask_value = $urandom_range(0, 1) ? MASK_INVALID_LO : MASK_INVALID_HI;
                end
                2:
                begin
                    r.duration_given = 1'b1;
                    r.duration = floor_ms[31:0] - 32'd1;
                end
                3:
                begin
                    r.duration_given = 1'b1;
                    r.duration = $urandom_range(0, floor_ms[31:0] - 32'd1);
                end
                4:
                begin
                    r.duration_given = 1'b1;
                    r.duration = $urandom_range(0, 1) ? {10'd0, max_dur_ms} + 32'd1
                                                      : 32'hFFFF_FFFF;
                end
                default: r.tracking = 1'b0;
            endcase
        end
        push_request(r);
        live_key = r.key;
        len = r.duration_given ? r.duration : {10'd0, dflt_dur_ms};
        reach = ({12'd0, hold_ms} + {2'd0, len}) / 3 + 34'd4;
        span = (reach > 34'h3FFF_FFFF) ? 32'h3FFF_FFFF : reach[31:0];
        loss = $urandom_range(0, 2);
        repeat ($urandom_range(2, 9))
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    r = make_request(REQ_ABORT, stim_now, live_key);
                    r.action = 2'($urandom_range(0, 2));
                    push_request(r);
                end
                1: push_request(make_request(REQ_REGISTER, stim_now, $urandom()));
                default: ;
            endcase
            stim_now = stim_now + $urandom_range(span / 4, span);
            r = make_request(REQ_TICK, stim_now, live_key);
            r.tracking = ($urandom_range(0, 3) >= loss);
            push_request(r);
        end
    endtask

    task automatic noise_request;
        request_t r;
        r.kind = 2'($urandom_range(0, 3));
        r.now = ($urandom_range(0, 9) == 0) ? $urandom() : stim_now + $urandom_range(0, 3000);
        r.key = ($urandom_range(0, 2) == 0) ? live_key : $urandom();
        r.key_valid = 1'($urandom_range(0, 1));
        r.action = 2'($urandom_range(0, 3));
        r.payload_bad = 1'($urandom_range(0, 1));
        r.mask_given = 1'($urandom_range(0, 1));
        r.mask_value = 2'($urandom_range(0, 3));
        r.duration_given = 1'($urandom_range(0, 1));
        r.duration = $urandom();
        r.tracking = 1'($urandom_range(0, 1));
        push_request(r);
    endtask

    task automatic random_phase;
        int first;
        int pick;
        request_t r;
        first = stim_items;
        while (stim_items - first < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                task_episode();
            else if (pick < 85)
                noise_request();
            else
            begin
                // Keys seen earlier: duplicates while recent, new again once evicted.
                r = make_request(REQ_REGISTER, stim_now,
                                 known_keys[$urandom_range(0, known_keys.size() - 1)]);
                r.tracking = 1'($urandom_range(0, 1));
                push_request(r);
            end
        end
    endtask

    initial
    begin
        request_t r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values.
        push_request(make_request(REQ_UNKNOWN, 32'd0, 32'h0000_1234));
        r = make_request(REQ_REGISTER, 32'd1, 32'h0000_00A5);
        r.key_valid = 1'b0;
        push_request(r);
        r = make_request(REQ_REGISTER, 32'd2, 32'h0000_00A6);
        r.action = ACT_ABSENT;
        push_request(r);
        r.action = ACT_OTHER;
        push_request(r);
        r = make_request(REQ_REGISTER, 32'd3, 32'h0000_0000);
        r.tracking = 1'b0;
        push_request(r);
        push_request(r);
        r = make_request(REQ_REGISTER, 32'd4, 32'd1);
        r.payload_bad = 1'b1;
        push_request(r);
        r = make_request(REQ_REGISTER, 32'd4, 32'd2);
        r.mask_given = 1'b1;
        r.mask_value = MASK_INVALID_LO;
        push_request(r);
        r.key = 32'd3;
        r.mask_value = MASK_INVALID_HI;
        push_request(r);
        r = make_request(REQ_REGISTER, 32'd4, 32'd4);
        r.duration_given = 1'b1;
        r.duration = 32'd2999;
        push_request(r);
        r.key = 32'd5;
        r.duration = 32'd600001;
        push_request(r);
        // Shortest legal run, started just below the time wrap.
        r = make_request(REQ_REGISTER, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        r.duration_given = 1'b1;
        r.duration = 32'd3000;
        r.mask_given = 1'b1;
        r.mask_value = MASK_SIDEWALK;
        push_request(r);
        push_request(make_request(REQ_REGISTER, 32'hFFFF_FF0A, 32'd6));
        push_request(make_request(REQ_ABORT, 32'hFFFF_FF0B, 32'hFFFF_FFFE));
        r = make_request(REQ_ABORT, 32'hFFFF_FF0C, 32'hFFFF_FFFF);
        r.action = ACT_OTHER;
        push_request(r);
        push_request(make_request(REQ_TICK, 32'hFFFF_FF00 + 32'd1999, 32'd0));
        push_request(make_request(REQ_TICK, 32'hFFFF_FF00 + 32'd2000, 32'd0));
        push_request(make_request(REQ_TICK, 32'hFFFF_FF00 + 32'd3000, 32'd0));
        push_request(make_request(REQ_TICK, 32'hFFFF_FF00 + 32'd3001, 32'd0));
        // Default duration, then a server abort.
        push_request(make_request(REQ_REGISTER, 32'd5000, 32'd7));
        r = make_request(REQ_ABORT, 32'd5100, 32'd7);
        r.action = ACT_ABSENT;
        push_request(r);
        // Longest legal run, ended by the unsafe timeout.
        r = make_request(REQ_REGISTER, 32'd10000, 32'd8);
        r.mask_given = 1'b1;
        r.mask_value = MASK_ROAD;
        r.duration_given = 1'b1;
        r.duration = 32'd600000;
        push_request(r);
        r = make_request(REQ_TICK, 32'd12000, 32'd0);
        r.tracking = 1'b0;
        push_request(r);
        r.now = 32'd12999;
        push_request(r);
        r.now = 32'd13000;
        push_request(r);
        // Duration reached without any earlier tracking tick.
        push_request(make_request(REQ_REGISTER, 32'd20000, 32'd9));
        push_request(make_request(REQ_TICK, 32'd50000, 32'd0));
        stim_now = 32'd100000;
        random_phase();

        settle();
        program_registers(22'd1, 22'd1, 22'd1, 22'd3600000, {20'd0, MASK_SIDEWALK});
        random_phase();

        settle();
        program_registers(22'd3600000, 22'd3600000, 22'd3600000, 22'd1, 22'h3FFFFD);
        random_phase();

        settle();
        program_registers(22'd50, 22'd200, 22'd2000, 22'd5000, {20'd0, MASK_INVALID_LO});
        random_phase();

        settle();
        program_registers(22'h3FFFFF, 22'd0, 22'd0, 22'h3FFFFF, {20'd0, MASK_INVALID_HI});
        random_phase();

        settle();
        program_registers(22'($urandom_range(1, 20000)), 22'($urandom_range(1, 5000)),
                          22'($urandom_range(1, 40000)), 22'($urandom_range(1000, 100000)),
                          22'($urandom_range(1, 2)));
        random_phase();

        settle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
